[sv/psds_pkg.sv]
// ----------------------------------------------------------------------------
// psds_pkg
// Shared types and constants for the parity split dual sorter.
// ----------------------------------------------------------------------------
package psds_pkg;

   localparam int VAL_W = 32;

   // Control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   // Signed order compare through the sign-flipped key
   function automatic logic key_lt(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
      key_lt = (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
   endfunction

endpackage

[sv/psds_ram.sv]
// ----------------------------------------------------------------------------
// psds_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module psds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/parity_split_dual_sort.sv]
// ----------------------------------------------------------------------------
// parity_split_dual_sort
// Loads a run of signed values, keeps even positions descending and odd
// positions ascending, and emits the interleaved run when the last request closes.
// ----------------------------------------------------------------------------
// Each request is inserted into one of two RAMs by a shift loop that reads one
// entry per cycle. A request whose list is empty is accepted and then written;
// otherwise it is accepted, the first entry is read, each moved entry is
// shifted up and a final write places the value. The request carrying last
// then emits its run: for each result the RAM read is issued, then the data
// is presented and held while the receiver stalls. Requests beyond MAX_LEN
// are dropped and flag overflow on every result of that run.
module parity_split_dual_sort #(
   parameter int MAX_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value_res
   output logic        rsp_tlast,   // last_res
   output logic        rsp_tuser    // overflow
);
   import psds_pkg::*;

   localparam int EVEN_D = (MAX_LEN + 1) / 2;
   localparam int RAM_D  = (EVEN_D > 1) ? EVEN_D : 2;
   localparam int AW     = $clog2(RAM_D);
   localparam int TW     = $clog2(MAX_LEN + 1);

   state_type state_ff, state_in;

   logic [TW-1:0]    total_ff, total_in;
   logic [AW:0]      ecnt_ff, ecnt_in, ocnt_ff, ocnt_in;
   logic             drop_ff, drop_in;
   logic             lastq_ff, lastq_in;
   logic [31:0]      x_ff, x_in;
   logic             odd_ff, odd_in;
   logic [AW:0]      pos_ff, pos_in;
   logic [TW-1:0]    k_ff, k_in;
   logic             olast_ff, olast_in;
   logic             ouser_ff, ouser_in;

   logic             e_we, o_we;
   logic [AW-1:0]    wa, ra;
   logic [31:0]      wd, e_rd, o_rd, cur_rd;
   logic             shift;
   logic [AW:0]      kidx;

   psds_ram #(.WIDTH(32), .DEPTH(RAM_D)) u_even (
      .clock(clock), .wr_en(e_we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(e_rd));
   psds_ram #(.WIDTH(32), .DEPTH(RAM_D)) u_odd (
      .clock(clock), .wr_en(o_we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(o_rd));

   assign cur_rd = odd_ff ? o_rd : e_rd;
   // Move the entry up while it is out of order with the new value
   assign shift  = odd_ff ? key_lt(x_ff, cur_rd) : key_lt(cur_rd, x_ff);
   assign kidx   = k_ff[TW-1:1];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (total_ff >= TW'(MAX_LEN)) begin
                  state_in = req_tlast ? ST_EMIT_RD : ST_IDLE;
               end else if ((total_ff[0] ? ocnt_ff : ecnt_ff) == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (shift && pos_ff != '0) state_in = ST_WRITE;
            else if (!shift || pos_ff == '0) state_in = lastq_ff ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (rsp_tready) begin
               state_in = olast_ff ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      total_in = total_ff; ecnt_in = ecnt_ff; ocnt_in = ocnt_ff; drop_in = drop_ff;
      lastq_in = lastq_ff; x_in = x_ff; odd_in = odd_ff; pos_in = pos_ff;
      k_in = k_ff; olast_in = olast_ff; ouser_in = ouser_ff;
      e_we = 1'b0; o_we = 1'b0; wa = pos_ff[AW-1:0]; wd = x_ff;
      ra = AW'(pos_ff - 1'b1);
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            k_in = '0;
            if (req_tvalid) begin
               x_in = req_tdata; lastq_in = req_tlast;
               odd_in = total_ff[0];
               pos_in = total_ff[0] ? ocnt_ff : ecnt_ff;
               if (total_ff >= TW'(MAX_LEN)) begin
                  drop_in = 1'b1;
               end else begin
                  total_in = total_ff + 1'b1;
                  if (total_ff[0]) ocnt_in = ocnt_ff + 1'b1;
                  else ecnt_in = ecnt_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // Read the entry below the hole
            ra = AW'(pos_ff - 1'b1);
         end
         ST_WRITE: begin
            if (pos_ff != '0 && shift) begin
               wd = cur_rd; pos_in = pos_ff - 1'b1;
               ra = AW'(pos_ff - 2'd2);
            end
            e_we = !odd_ff; o_we = odd_ff;
         end
         ST_EMIT_RD: begin
            ra = kidx[AW-1:0];
            odd_in = k_ff[0];
         end
         ST_EMIT_OUT: begin
            ra = kidx[AW-1:0];
            if (rsp_tready) begin
               k_in = k_ff + 1'b1;
               if (olast_ff) begin
                  total_in = '0; ecnt_in = '0; ocnt_in = '0; drop_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      olast_in = (k_ff + 1'b1) == total_ff;
      ouser_in = drop_ff;
   end

   // Advance the sequencer and hold the datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0; ecnt_ff <= '0; ocnt_ff <= '0; drop_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in; ecnt_ff <= ecnt_in; ocnt_ff <= ocnt_in;
         drop_ff <= drop_in; k_ff <= k_in;
      end
      lastq_ff <= lastq_in; x_ff <= x_in; odd_ff <= odd_in; pos_ff <= pos_in;
      olast_ff <= olast_in; ouser_ff <= ouser_in;
   end

   assign rsp_tvalid = (state_ff == ST_EMIT_OUT);
   assign rsp_tdata  = cur_rd;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ouser_ff;

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept during emit");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(MAX_LEN)) else $error("count overrun");
   a_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> TW'(ecnt_ff) + TW'(ocnt_ff) == total_ff)
      else $error("count mismatch");
endmodule
